FILE: sv/ckm_pkg.sv
// Shared types and constants for the 3x3 color-key morphology block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ckm_pkg;

    localparam int PIX_W      = 24;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    localparam logic [DIM_W-1:0] RESET_DIM = 11'd1024;

    typedef struct packed {
        logic [PIX_W-1:0] key;
        logic             mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    // one classified request: the 3x3 window, col*3+row, 0 = top left
    typedef struct packed {
        logic [8:0][PIX_W-1:0] win;
        logic                  interior;
        logic                  last;
    } t_entry;

endpackage

`default_nettype wire

FILE: sv/ckm_fifo.sv
// Short request queue between the front and back parts of the morphology block.
// Depends on ckm_pkg for the entry type and depth.
`default_nettype none

module ckm_fifo import ckm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_entry                i_entry,
    input  wire logic                  i_pop,
    output      t_entry                o_head,
    output      logic                  o_empty,
    output      logic [FIFO_CNT_W-1:0] o_count
);

    t_entry                r_slot [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + FIFO_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // the front's credit check must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("request queue underflow");

endmodule

`default_nettype wire

FILE: sv/ckm_front.sv
// Front part: frame counters, line store with clearing pass, 3x3 window and
// classification of each pixel. Depends on ckm_pkg.
`default_nettype none

module ckm_front import ckm_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire logic [PIX_W-1:0]      i_pixel,
    input  wire logic [FIFO_CNT_W-1:0] i_fifo_count,
    output      logic                  o_push,
    output      t_entry                o_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int CX = WW + 1;
    localparam int RX = RW + 1;

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic [CX-1:0] col_inc;
    logic [RX-1:0] h_plus1;
    logic [RX-1:0] pr;
    logic [CX-1:0] pc;
    logic          emit;
    logic          interior;
    logic          last;
    logic          accept;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    logic               r_clr_busy;
    logic [CW-1:0]      r_clr_addr;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic               mem_we;
    logic [CW-1:0]      mem_wa;
    logic [2*PIX_W-1:0] mem_wd;

    logic               r_s2_valid;
    logic [PIX_W-1:0]   r_s2_px;
    logic [CW-1:0]      r_s2_col;
    logic               r_s2_emit;
    logic               r_s2_int;
    logic               r_s2_last;
    logic               r_fwd;
    logic [2*PIX_W-1:0] r_fwd_word;

    logic [2*PIX_W-1:0] word;
    logic [2*PIX_W-1:0] wr_word;
    logic [8:0][PIX_W-1:0] r_win;
    logic [8:0][PIX_W-1:0] n_win;

    // saturate the frame size
    always_comb begin
        if (i_cfg.width == '0) begin
            w = WW'(1);
        end else if (32'(i_cfg.width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h = HW'(1);
        end else if (32'(i_cfg.height) > 32'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(i_cfg.height);
        end
    end

    // position of this pixel and its classification
    always_comb begin
        h_plus1 = RX'(h) + RX'(1);
        if (CX'(r_col) >= CX'(w)) begin
            col = CW'(w - WW'(1));
        end else begin
            col = r_col;
        end
        if (RX'(r_row) > h_plus1) begin
            row = RW'(h_plus1);
        end else begin
            row = r_row;
        end

        emit = !((row == '0) || ((row == RW'(1)) && (col == '0)));

        if (col == '0) begin
            pr = RX'(row) - RX'(2);
            pc = CX'(w) - CX'(1);
        end else begin
            pr = RX'(row) - RX'(1);
            pc = CX'(col) - CX'(1);
        end
        interior = (pr >= RX'(1)) && ((pr + RX'(2)) <= RX'(h))
                && (pc >= CX'(1)) && ((pc + CX'(2)) <= CX'(w));
        last = ((pr + RX'(1)) >= RX'(h)) && (pc == (CX'(w) - CX'(1)));

        col_inc = CX'(col) + CX'(1);
        if (col_inc >= CX'(w)) begin
            n_col = '0;
            n_row = RW'(RX'(row) + RX'(1));
        end else begin
            n_col = CW'(col_inc);
            n_row = row;
        end
        if (emit && last) begin
            n_col = '0;
            n_row = '0;
        end
    end

    // hold input while clearing, and reserve a queue slot for each pixel in flight
    assign o_ready = !r_clr_busy
                  && ((FIFO_CNT_W'(i_fifo_count) + FIFO_CNT_W'(r_s2_valid))
                      < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s2_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_win      <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CW'(1);
                if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s2_valid <= accept;
            r_fwd      <= accept && r_s2_valid && (r_s2_col == col);
            if (r_s2_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_px   <= i_pixel;
            r_s2_col  <= col;
            r_s2_emit <= emit;
            r_s2_int  <= interior;
            r_s2_last <= last;
        end
        r_fwd_word <= wr_word;
    end

    // line store: low half holds row r-2, high half row r-1
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[col];
        end
    end

    // take the word written in the same cycle as the read, if any
    always_comb begin
        word    = r_fwd ? r_fwd_word : r_rd;
        wr_word = {r_s2_px, word[2*PIX_W-1:PIX_W]};
        n_win[5:0] = r_win[8:3];
        n_win[6]   = word[PIX_W-1:0];
        n_win[7]   = word[2*PIX_W-1:PIX_W];
        n_win[8]   = r_s2_px;
    end

    assign mem_we = r_clr_busy || r_s2_valid;
    assign mem_wa = r_clr_busy ? r_clr_addr : r_s2_col;
    assign mem_wd = r_clr_busy ? '0 : wr_word;

    assign o_push           = r_s2_valid && r_s2_emit;
    assign o_entry.win      = n_win;
    assign o_entry.interior = r_s2_int;
    assign o_entry.last     = r_s2_last;

    a_fwd_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s2_valid)
        else $error("forwarded line word without a pixel in flight");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit && last) |=> ((r_col == '0) && (r_row == '0)))
        else $error("counters did not restart after frame end");

    a_clear_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s2_valid)
        else $error("pixel in flight during line store clear");

endmodule

`default_nettype wire

FILE: sv/ckm_back.sv
// Back part: applies dilate or erode to each queued interior window (border pixels
// pass through) and holds the result in the output register. Depends on ckm_pkg.
`default_nettype none

module ckm_back import ckm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire t_entry           i_head,
    input  wire logic             i_empty,
    output      logic             o_pop,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      logic [PIX_W-1:0] o_pixel,
    output      logic             o_last
);

    // neighbour search order: left column, centre top and bottom, right column
    localparam logic [3:0] NB_IDX [8] = '{4'd0, 4'd1, 4'd2, 4'd3,
                                          4'd5, 4'd6, 4'd7, 4'd8};

    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic             r_last;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] first_ne;
    logic [PIX_W-1:0] result;
    logic [7:0]       nb_key;
    logic             center_key;

    always_comb begin
        center     = i_head.win[4];
        center_key = (center == i_cfg.key);
        first_ne   = center;
        for (int k = 7; k >= 0; k--) begin
            nb_key[k] = (i_head.win[NB_IDX[k]] == i_cfg.key);
            if (!nb_key[k]) begin
                first_ne = i_head.win[NB_IDX[k]];
            end
        end

        result = center;
        if (i_head.interior) begin
            if (i_cfg.mode == MODE_DILATE) begin
                if (!center_key && (nb_key != '0)) begin
                    result = i_cfg.key;
                end
            end else if (center_key) begin
                result = first_ne;
            end
        end
    end

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pixel <= result;
            r_last  <= i_head.last;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

`default_nettype wire

FILE: sv/color_key_morphology_3x3_top.sv
// Top level of the 3x3 color-key morphology block: configuration registers
// and the front, request queue and back parts. Depends on ckm_pkg, ckm_front,
// ckm_fifo and ckm_back.
//
// Usage:
//   Pixels arrive row-major on the s_axis channel (tdata = pixel_rgb,
//   tuser = is_padding) and results leave on m_axis (tdata = pixel_out,
//   tlast = frame_end). A result for a pixel appears once the pixel below
//   and to the right of it has been taken: the first image_width+1 items
//   of a frame give no result, so after each frame send image_width+1
//   padding items to flush it. The padding flag itself is not looked at.
//   Throughput is one pixel per clock while the receiver keeps up. A pixel
//   is registered with its line store word when it is accepted, then the
//   window register is updated and the request enters the queue; from the
//   queue head it is loaded into the output register once that is free.
//   Reset clears the counters, the window and the configuration registers
//   (width and height 1024), then sweeps the line store to zero, one
//   column a cycle over all MAX_WIDTH columns, with s_axis_tready low.
//   When the receiver stalls, the output register holds its result, a
//   four-entry request queue absorbs pixels in flight, and tready drops
//   once the queue has no free slot left for them.
//   Write configuration only while no frame is in progress.
`default_nettype none

module color_key_morphology_3x3_top import ckm_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [PIX_W-1:0]      s_axis_tdata,  // [23:0] pixel_rgb
    input  wire logic                  s_axis_tuser,  // [0] is_padding
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [PIX_W-1:0]      m_axis_tdata,  // [23:0] pixel_out
    output      logic                  m_axis_tlast,  // frame_end
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  push;
    t_entry                push_entry;
    logic                  pop;
    t_entry                head;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] fifo_count;

    // configuration registers; writes take effect at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key    <= '0;
            r_cfg.mode   <= MODE_DILATE;
            r_cfg.width  <= RESET_DIM;
            r_cfg.height <= RESET_DIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY:    r_cfg.key    <= i_cfg_data[PIX_W-1:0];
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: counters, line store, window, classification
    ckm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pixel      (s_axis_tdata),
        .i_fifo_count (fifo_count),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // decouple classification from the output side
    ckm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_count (fifo_count)
    );

    // back: morphology and output register
    ckm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pixel (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
